@@ design/bbcl_pkg.sv @@
// Shared types and constants for the buffer cache slot table.
`default_nettype none
package bbcl_pkg;

   localparam int DEV_W   = 8;
   localparam int BLK_W   = 32;
   localparam int COUNT_W = 8;
   localparam int TIME_W  = 32;
   localparam int SLOT_W  = 5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      OP_GET     = 2'd0,
      OP_RELEASE = 2'd1,
      OP_PIN     = 2'd2,
      OP_UNPIN   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NOFREE = 2'd1,
      ST_UNDER  = 2'd2,
      ST_OVER   = 2'd3
   } status_type;

   typedef struct packed {
      logic [DEV_W-1:0]   dev;
      logic [BLK_W-1:0]   blk;
      logic [COUNT_W-1:0] count;
      logic [TIME_W-1:0]  last;
      logic               valid;
   } entry_type;

endpackage
`default_nettype wire

@@ design/bbcl_if.sv @@
// Request and response channel interfaces of the buffer cache slot table.
`default_nettype none
interface bbcl_req_if import bbcl_pkg::*;;
   logic              valid;
   logic              ready;
   op_type            op;
   logic [DEV_W-1:0]  device;
   logic [BLK_W-1:0]  block_number;
   logic [SLOT_W-1:0] slot_in;
   logic [TIME_W-1:0] time_now;

   modport source (output valid, op, device, block_number, slot_in, time_now, input ready);
   modport sink (input valid, op, device, block_number, slot_in, time_now, output ready);
endinterface

interface bbcl_rsp_if import bbcl_pkg::*;;
   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] slot_out;
   logic              hit;
   logic              need_read;
   status_type        status;

   modport source (output valid, slot_out, hit, need_read, status, input ready);
   modport sink (input valid, slot_out, hit, need_read, status, output ready);
endinterface
`default_nettype wire

@@ design/block_buffer_cache_lru_unit.sv @@
// Buffer cache slot table: tag lookup, LRU victim choice and reference counting.
//
//   channel  dir  beat payload
//   req_ch   in   op, device, block_number, slot_in, time_now
//   rsp_ch   out  slot_out, hit, need_read, status
//
// Get: a scan that reads one slot per cycle from the slot memory (one read port,
// registered read).
// Release, pin, unpin: one read and, when the count changes, one write-back of the slot.
// Reset: synchronous; per-slot init flags make every slot read as zero.
// A request is taken while a response waits; the finishing step holds until
// the response register is free.
`default_nettype none
module block_buffer_cache_lru_unit import bbcl_pkg::*; #(
   parameter int SLOTS = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   bbcl_req_if.sink    req_ch,
   bbcl_rsp_if.source  rsp_ch
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = IW + 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
   localparam logic [CW-1:0] SLOT_CNT = CW'(SLOTS);

   typedef enum logic [3:0] {
      S_IDLE      = 4'b0001,
      S_SCAN      = 4'b0010,
      S_GET_DONE  = 4'b0100,
      S_SLOT_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // slot memory
   entry_type mem [SLOTS];
   logic [SLOTS-1:0] init_ff;
   entry_type rd_data_ff;
   logic      rd_init_ff;
   logic      rd_en;
   logic [IW-1:0] rd_addr;
   logic      mem_we;
   logic [IW-1:0] mem_wa;
   entry_type mem_wd;
   entry_type entry_q;

   // scan control
   logic [CW-1:0] issue_ff, issue_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;

   // latched request
   op_type            op_ff, op_in;
   logic [DEV_W-1:0]  dev_ff, dev_in;
   logic [BLK_W-1:0]  blk_ff, blk_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [TIME_W-1:0] time_ff, time_in;

   // scan results
   logic          hit_found_ff, hit_found_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in;
   entry_type     hit_entry_ff, hit_entry_in;
   logic          vic_found_ff, vic_found_in;
   logic [IW-1:0] vic_idx_ff, vic_idx_in;
   logic [TIME_W-1:0] vic_last_ff, vic_last_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic              rsp_rd_ff, rsp_rd_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic out_free;
   logic slot_ok;

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.slot_out  = rsp_slot_ff;
   assign rsp_ch.hit       = rsp_hit_ff;
   assign rsp_ch.need_read = rsp_rd_ff;
   assign rsp_ch.status    = rsp_status_ff;

   assign entry_q  = rd_init_ff ? rd_data_ff : '0;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign slot_ok  = (int'(slot_ff) < SLOTS);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_init_ff <= init_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= '0;
      end else if (mem_we) begin
         init_ff[mem_wa] <= 1'b1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      issue_in      = issue_ff;
      rd_vld_in     = rd_vld_ff;
      rd_idx_in     = rd_idx_ff;
      op_in         = op_ff;
      dev_in        = dev_ff;
      blk_in        = blk_ff;
      slot_in       = slot_ff;
      time_in       = time_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_entry_in  = hit_entry_ff;
      vic_found_in  = vic_found_ff;
      vic_idx_in    = vic_idx_ff;
      vic_last_in   = vic_last_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_rd_in     = rsp_rd_ff;
      rsp_status_in = rsp_status_ff;
      rd_en         = 1'b0;
      rd_addr       = issue_ff[IW-1:0];
      mem_we        = 1'b0;
      mem_wa        = IW'(slot_ff);
      mem_wd        = entry_q;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in     = req_ch.op;
               dev_in    = req_ch.device;
               blk_in    = req_ch.block_number;
               slot_in   = req_ch.slot_in;
               time_in   = req_ch.time_now;
               if (req_ch.op == OP_GET) begin
                  issue_in     = '0;
                  rd_vld_in    = 1'b0;
                  hit_found_in = 1'b0;
                  vic_found_in = 1'b0;
                  state_in     = S_SCAN;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = IW'(req_ch.slot_in);
                  state_in = S_SLOT_DONE;
               end
            end
         end
         S_SCAN: begin
            rd_vld_in = 1'b0;
            if (issue_ff < SLOT_CNT) begin
               rd_en     = 1'b1;
               rd_addr   = issue_ff[IW-1:0];
               rd_vld_in = 1'b1;
               rd_idx_in = issue_ff[IW-1:0];
               issue_in  = issue_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               // lowest matching slot wins
               if (!hit_found_ff && entry_q.dev == dev_ff && entry_q.blk == blk_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = rd_idx_ff;
                  hit_entry_in = entry_q;
               end
               // strict compare keeps the lowest slot on a tie
               if (entry_q.count == '0 && (!vic_found_ff || entry_q.last < vic_last_ff)) begin
                  vic_found_in = 1'b1;
                  vic_idx_in   = rd_idx_ff;
                  vic_last_in  = entry_q.last;
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = S_GET_DONE;
               end
            end
         end
         S_GET_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (hit_found_ff) begin
                  rsp_slot_in = SLOT_W'(hit_idx_ff);
                  rsp_hit_in  = 1'b1;
                  if (hit_entry_ff.count == COUNT_MAX) begin
                     rsp_rd_in     = 1'b0;
                     rsp_status_in = ST_OVER;
                  end else begin
                     rsp_rd_in     = !hit_entry_ff.valid;
                     rsp_status_in = ST_OK;
                     mem_we        = 1'b1;
                     mem_wa        = hit_idx_ff;
                     mem_wd        = hit_entry_ff;
                     mem_wd.count  = hit_entry_ff.count + 1'b1;
                     mem_wd.valid  = 1'b1;
                  end
               end else if (vic_found_ff) begin
                  rsp_slot_in   = SLOT_W'(vic_idx_ff);
                  rsp_hit_in    = 1'b0;
                  rsp_rd_in     = 1'b1;
                  rsp_status_in = ST_OK;
                  mem_we        = 1'b1;
                  mem_wa        = vic_idx_ff;
                  mem_wd.dev    = dev_ff;
                  mem_wd.blk    = blk_ff;
                  mem_wd.count  = COUNT_W'(1);
                  mem_wd.last   = vic_last_ff;
                  mem_wd.valid  = 1'b1;
               end else begin
                  rsp_slot_in   = '0;
                  rsp_hit_in    = 1'b0;
                  rsp_rd_in     = 1'b0;
                  rsp_status_in = ST_NOFREE;
               end
            end
         end
         S_SLOT_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = slot_ff;
               rsp_hit_in    = 1'b0;
               rsp_rd_in     = 1'b0;
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
               mem_wa        = IW'(slot_ff);
               mem_wd        = entry_q;
               if (slot_ok) begin
                  if (op_ff == OP_PIN) begin
                     if (entry_q.count == COUNT_MAX) begin
                        rsp_status_in = ST_OVER;
                     end else begin
                        mem_we       = 1'b1;
                        mem_wd.count = entry_q.count + 1'b1;
                     end
                  end else if (entry_q.count == '0) begin
                     rsp_status_in = ST_UNDER;
                  end else begin
                     mem_we       = 1'b1;
                     mem_wd.count = entry_q.count - 1'b1;
                     // release stamps the time when the last reference goes
                     if (op_ff == OP_RELEASE && entry_q.count == COUNT_W'(1)) begin
                        mem_wd.last = time_ff;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff      <= issue_in;
      rd_idx_ff     <= rd_idx_in;
      op_ff         <= op_in;
      dev_ff        <= dev_in;
      blk_ff        <= blk_in;
      slot_ff       <= slot_in;
      time_ff       <= time_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      hit_entry_ff  <= hit_entry_in;
      vic_found_ff  <= vic_found_in;
      vic_idx_ff    <= vic_idx_in;
      vic_last_ff   <= vic_last_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_rd_ff     <= rsp_rd_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
`default_nettype wire

@@ test/block_buffer_cache_lru_unit_test.sv @@
// Self-checking testbench for the buffer cache slot table: directed, fill/overflow and random beats.
module block_buffer_cache_lru_unit_test;
   import bbcl_pkg::*;

   localparam int NSLOTS = 32;
   localparam int LIMIT = 1000000;
   localparam int POOL = 40;

   typedef struct {
      logic [SLOT_W-1:0] slot;
      logic              hit;
      logic              need_read;
      status_type        status;
   } cache_reply_type;

   // Tracks the slot table and queues the reply each request must produce.
   class slot_table_model_type;
      logic [DEV_W-1:0]   tag_dev [NSLOTS];
      logic [BLK_W-1:0]   tag_blk [NSLOTS];
      logic [COUNT_W-1:0] count [NSLOTS];
      logic [TIME_W-1:0]  last [NSLOTS];
      logic               filled [NSLOTS];
      cache_reply_type    pending[$];
      int errors, n_req, n_get, n_hit, n_refill, n_nofree, n_under, n_over;

      function new();
         for (int i = 0; i < NSLOTS; i++) begin
            tag_dev[i] = '0;
            tag_blk[i] = '0;
            count[i] = '0;
            last[i] = '0;
            filled[i] = 1'b0;
         end
         errors = 0; n_req = 0; n_get = 0; n_hit = 0;
         n_refill = 0; n_nofree = 0; n_under = 0; n_over = 0;
      endfunction

      function void take_request(op_type op, logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk,
                                 logic [SLOT_W-1:0] slot, logic [TIME_W-1:0] now);
         cache_reply_type r;
         int sel;
         bit found;
         n_req++;
         found = 0;
         sel = 0;
         r = '{slot: slot, hit: 1'b0, need_read: 1'b0, status: ST_OK};
         if (op == OP_GET) begin
            n_get++;
            for (int i = 0; i < NSLOTS; i++)
               if (!found && tag_dev[i] == dev && tag_blk[i] == blk) begin
                  found = 1;
                  sel = i;
               end
            if (found) begin
               r.slot = SLOT_W'(sel);
               r.hit = 1'b1;
               if (count[sel] == COUNT_MAX) begin
                  r.status = ST_OVER;
                  n_over++;
               end else begin
                  count[sel]++;
                  r.need_read = !filled[sel];
                  filled[sel] = 1'b1;
                  n_hit++;
               end
            end else begin
               // oldest free slot, lowest index on a tie
               for (int i = 0; i < NSLOTS; i++)
                  if (count[i] == 0 && (!found || last[i] < last[sel])) begin
                     found = 1;
                     sel = i;
                  end
               if (!found) begin
                  r.slot = '0;
                  r.status = ST_NOFREE;
                  n_nofree++;
               end else begin
                  tag_dev[sel] = dev;
                  tag_blk[sel] = blk;
                  count[sel] = COUNT_W'(1);
                  filled[sel] = 1'b1;
                  r.slot = SLOT_W'(sel);
                  r.need_read = 1'b1;
                  n_refill++;
               end
            end
         end else if (op == OP_PIN) begin
            if (count[slot] == COUNT_MAX) begin
               r.status = ST_OVER;
               n_over++;
            end else
               count[slot]++;
         end else if (count[slot] == 0) begin
            r.status = ST_UNDER;
            n_under++;
         end else begin
            count[slot]--;
            if (op == OP_RELEASE && count[slot] == 0)
               last[slot] = now;
         end
         pending.push_back(r);
      endfunction

      function void check_reply(logic [SLOT_W-1:0] slot, logic hit, logic need_read,
                                status_type status);
         cache_reply_type e;
         if (pending.size() == 0) begin
            $display("%0t: reply with none outstanding: slot %0d hit %b read %b status %0d",
                     $time, slot, hit, need_read, status);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (slot !== e.slot || hit !== e.hit || need_read !== e.need_read ||
             status !== e.status) begin
            $display("%0t: reply mismatch: expected slot %0d hit %b read %b status %s",
                     $time, e.slot, e.hit, e.need_read, e.status.name());
            $display("%0t:                 actual   slot %0d hit %b read %b status %0d",
                     $time, slot, hit, need_read, status);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle;
   int   rsp_idle;
   int   cycles;
   logic [TIME_W-1:0] tick;
   logic [DEV_W-1:0]  pool_dev [POOL];
   logic [BLK_W-1:0]  pool_blk [POOL];

   slot_table_model_type ledger = new();

   bbcl_req_if req_ch ();
   bbcl_rsp_if rsp_ch ();

   block_buffer_cache_lru_unit #(.SLOTS(NSLOTS)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d replies outstanding", cycles,
               ledger.pending.size());
      $display("block_buffer_cache_lru_unit test failed");
      $finish;
   end

   // reply side: sample at the rising edge, move ready at the falling edge
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            ledger.check_reply(rsp_ch.slot_out, rsp_ch.hit, rsp_ch.need_read, rsp_ch.status);
         @(negedge clock);
         rsp_ch.ready = ($urandom_range(99) >= rsp_idle);
      end
   end

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_req(op_type op, logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk,
                           logic [SLOT_W-1:0] slot, logic [TIME_W-1:0] now);
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.op = op;
      req_ch.device = dev;
      req_ch.block_number = blk;
      req_ch.slot_in = slot;
      req_ch.time_now = now;
      do @(posedge clock); while (!req_ch.ready);
      ledger.take_request(op, dev, blk, slot, now);
      @(negedge clock);
   endtask

   task automatic wait_for_replies();
      req_ch.valid = 1'b0;
      while (ledger.pending.size() != 0)
         @(negedge clock);
   endtask

   task automatic random_req();
      int r;
      int p;
      int busy[$];
      op_type op;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] now;
      tick += $urandom_range(3);
      now = ($urandom_range(99) < 5) ? $urandom : tick;
      r = $urandom_range(99);
      if (r < 40) begin
         if ($urandom_range(99) < 65) begin
            p = $urandom_range(POOL - 1);
            send_req(OP_GET, pool_dev[p], pool_blk[p], SLOT_W'($urandom), now);
         end else
            send_req(OP_GET, DEV_W'($urandom), $urandom, SLOT_W'($urandom), now);
      end else begin
         op = (r < 70) ? OP_RELEASE : (r < 80) ? OP_PIN : OP_UNPIN;
         for (int i = 0; i < NSLOTS; i++)
            if (ledger.count[i] != 0)
               busy.push_back(i);
         if (busy.size() != 0 && $urandom_range(99) < 80)
            slot = SLOT_W'(busy[$urandom_range(busy.size() - 1)]);
         else
            slot = SLOT_W'($urandom);
         send_req(op, DEV_W'($urandom), $urandom, slot, now);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.op = OP_GET;
      req_ch.device = '0;
      req_ch.block_number = '0;
      req_ch.slot_in = '0;
      req_ch.time_now = '0;
      send_idle = 13;
      rsp_idle = 45;
      tick = '0;
      for (int i = 0; i < POOL; i++) begin
         pool_dev[i] = DEV_W'($urandom_range(3));
         pool_blk[i] = $urandom;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // after reset every slot is tagged (0,0) but not filled
      send_req(OP_GET, 8'h00, 32'h0000_0000, 5'd0, 32'd0);
      send_req(OP_GET, 8'h00, 32'h0000_0000, 5'd0, 32'd0);
      send_req(OP_RELEASE, 8'h00, 32'h0, 5'd0, 32'd5);
      send_req(OP_UNPIN, 8'h00, 32'h0, 5'd0, 32'd9);
      send_req(OP_UNPIN, 8'h00, 32'h0, 5'd0, 32'd9);
      send_req(OP_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
      send_req(OP_PIN, 8'h00, 32'h0, 5'd31, 32'd0);
      send_req(OP_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'd0);
      send_req(OP_RELEASE, 8'h00, 32'h0, 5'd31, 32'hFFFF_FFFF);
      send_req(OP_PIN, 8'h00, 32'h0, 5'd2, 32'd0);
      send_req(OP_RELEASE, 8'h00, 32'h0, 5'd2, 32'd0);
      send_req(OP_GET, 8'h5A, 32'hA5A5_A5A5, 5'd31, 32'd0);
      send_req(OP_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'd0);
      send_req(OP_RELEASE, 8'h00, 32'h0, 5'd0, 32'd3);
      send_req(OP_RELEASE, 8'h00, 32'h0, 5'd0, 32'd3);
      send_req(OP_UNPIN, 8'h00, 32'h0, 5'd0, 32'd0);
      send_req(OP_GET, 8'hA5, 32'h5A5A_5A5A, 5'd0, 32'd7);
      send_req(OP_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'd0);
      wait_for_replies();

      // fill every free slot with fresh tags; the gets beyond that find no free slot
      for (int k = 0; k < NSLOTS + 2; k++)
         send_req(OP_GET, 8'(k), 32'h8000_0000 | k, 5'd0, tick);

      // drive one slot to the count ceiling and past it, then down to zero and one unpin past it
      while (ledger.count[7] != COUNT_MAX)
         send_req(OP_PIN, 8'h00, 32'h0, 5'd7, tick);
      send_req(OP_PIN, 8'h00, 32'h0, 5'd7, tick);
      send_req(OP_GET, ledger.tag_dev[7], ledger.tag_blk[7], 5'd0, tick);
      while (ledger.count[7] != 0)
         send_req(OP_UNPIN, 8'h00, 32'h0, 5'd7, tick);
      send_req(OP_UNPIN, 8'h00, 32'h0, 5'd7, tick);

      // free everything with scattered stamps so the LRU order is nontrivial
      for (int s = 0; s < NSLOTS; s++)
         while (ledger.count[s] != 0)
            send_req(OP_RELEASE, 8'h00, 32'h0, SLOT_W'(s), $urandom);
      wait_for_replies();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 13 : (ph == 1) ? 45 : 0;
         rsp_idle = (ph == 0) ? 45 : (ph == 1) ? 13 : 0;
         for (int n = 0; n < 470; n++) begin
            random_req();
            if ($urandom_range(99) == 0)
               wait_for_replies();
         end
         wait_for_replies();
      end

      repeat (2 * NSLOTS + 10) @(negedge clock);
      $display("%0d requests, %0d gets: %0d hits, %0d refills, %0d with no free slot",
               ledger.n_req, ledger.n_get, ledger.n_hit, ledger.n_refill, ledger.n_nofree);
      $display("count underflows %0d, count overflows %0d, mismatches %0d",
               ledger.n_under, ledger.n_over, ledger.errors);
      if (ledger.pending.size() != 0)
         $display("%0d expected replies never arrived", ledger.pending.size());
      if (ledger.errors == 0 && ledger.pending.size() == 0)
         $display("block_buffer_cache_lru_unit test passed");
      else
         $display("block_buffer_cache_lru_unit test failed");
      $finish;
   end

endmodule

@@ sim.f @@
design/bbcl_pkg.sv
design/bbcl_if.sv
design/block_buffer_cache_lru_unit.sv
test/block_buffer_cache_lru_unit_test.sv
